// ----- rtl/core/sorp_pkg.sv -----
// Shared types, sizes and helper functions of the slope-one rating predictor.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sorp_pkg;

	// Sizing of the item space and of one user's list.
	localparam int NUM_ITEMS  = 64;
	localparam int MAX_PREFS  = 16;
	localparam int RESULT_CAP = 64;

	// Field widths.
	localparam int ITEM_W = 6;
	localparam int RAT_W  = 16;
	localparam int CNT_W  = 24;
	localparam int SUM_W  = 40;
	localparam int WGT_W  = 28;
	localparam int WORD_W = SUM_W + CNT_W;

	// Pair table geometry.
	localparam int TBL_DEPTH = NUM_ITEMS * NUM_ITEMS;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int CLR_W     = $clog2(TBL_DEPTH + 1);

	// List and loop counters.
	localparam int LEN_W = $clog2(MAX_PREFS + 1);
	localparam int IDX_W = (MAX_PREFS > 1) ? $clog2(MAX_PREFS) : 1;
	localparam int T_W   = $clog2(NUM_ITEMS + 1);
	localparam int N_W   = $clog2(RESULT_CAP + 1);

	// Prediction accumulator widths.
	localparam int PROD_W = RAT_W + CNT_W + 1;
	localparam int TERM_W = PROD_W + 1;
	localparam int NUM_W  = TERM_W + $clog2(MAX_PREFS);
	localparam int TOT_W  = CNT_W + $clog2(MAX_PREFS);
	localparam int DCNT_W = $clog2(NUM_W + 1);

	// Queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Saturation limits.
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
	localparam logic [WGT_W-1:0] WEIGHT_MAX = {WGT_W{1'b1}};
	localparam logic signed [RAT_W-1:0] Q_MAX = {1'b0, {(RAT_W-1){1'b1}}};
	localparam logic signed [RAT_W-1:0] Q_MIN = {1'b1, {(RAT_W-1){1'b0}}};
	localparam int Q_POS_LIM = 32767;
	localparam int Q_NEG_LIM = 32768;

	// Mode codes.
	localparam logic MODE_TRAIN   = 1'b0;
	localparam logic MODE_PREDICT = 1'b1;

	// One classified preference word as it travels through the queue.
	typedef struct packed {
		logic                    mode;
		logic [ITEM_W-1:0]       item;
		logic signed [RAT_W-1:0] rating;
		logic                    last;
		logic                    keep;
	} entry_t;

	// Status that gates the front.
	typedef struct packed {
		logic clr_busy;
		logic q_full;
	} fe_ctl_t;

	// Divider status.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TA,
		ST_TRD,
		ST_TWR,
		ST_PT,
		ST_PRD,
		ST_PMUL,
		ST_PACC,
		ST_PCHK,
		ST_PDIV,
		ST_PPUSH,
		ST_PFIN
	} back_state_t;

	// Pair table address of the ordered pair (a, b).
	function automatic logic [ADDR_W-1:0] slot(input logic [ITEM_W-1:0] a,
			input logic [ITEM_W-1:0] b);
		return ADDR_W'(int'(a) * NUM_ITEMS + int'(b));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sorp_front.sv -----
// Front end: accepts preference words and classifies them as kept or dropped.
// Depends on sorp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorp_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mode,
	input  wire logic [sorp_pkg::ITEM_W-1:0]     item,
	input  wire logic signed [sorp_pkg::RAT_W-1:0] rating,
	input  wire logic                            last,
	input  wire sorp_pkg::fe_ctl_t               ctl,
	output logic                                 push,
	output sorp_pkg::entry_t                     entry
);

	logic [sorp_pkg::LEN_W-1:0] fill_q;
	logic                       keep;

	// Hold off while the table is cleared or the queue is full.
	assign in_stall = ctl.clr_busy | ctl.q_full;
	assign push     = in_valid & ~in_stall;

	// A word is kept while the list has room and its item is in range.
	assign keep = (32'(fill_q) < sorp_pkg::MAX_PREFS) && (32'(item) < sorp_pkg::NUM_ITEMS);

	always_comb begin
		entry.mode   = mode;
		entry.item   = item;
		entry.rating = rating;
		entry.last   = last;
		entry.keep   = keep;
	end

	// Track the list fill; a closing word starts a new list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			if (last) begin
				fill_q <= '0;
			end else if (keep) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorp_fifo.sv -----
// Short queue of classified words between the front and the back.
// Depends on sorp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sorp_pkg::entry_t wr_entry,
	input  wire logic             pop,
	output sorp_pkg::entry_t      rd_entry,
	output logic                  full,
	output logic                  empty
);

	sorp_pkg::entry_t                  slots_q [sorp_pkg::FIFO_DEPTH];
	logic [sorp_pkg::FIFO_IDX_W-1:0]   wr_ptr_q;
	logic [sorp_pkg::FIFO_IDX_W-1:0]   rd_ptr_q;
	logic [sorp_pkg::FIFO_CNT_W-1:0]   cnt_q;

	assign full     = (32'(cnt_q) == sorp_pkg::FIFO_DEPTH);
	assign empty    = (cnt_q == '0);
	assign rd_entry = slots_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the prediction quotient.
// Depends on sorp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [sorp_pkg::NUM_W-1:0]    dividend,
	input  wire logic [sorp_pkg::TOT_W-1:0]    divisor,
	output logic [sorp_pkg::NUM_W-1:0]         quotient,
	output sorp_pkg::div_stat_t                stat
);

	logic [sorp_pkg::NUM_W-1:0]  dvd_q;
	logic [sorp_pkg::TOT_W-1:0]  dsr_q;
	logic [sorp_pkg::TOT_W-1:0]  rem_q;
	logic [sorp_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [sorp_pkg::TOT_W:0]    trial;
	logic                        qbit;
	logic [sorp_pkg::TOT_W:0]    diff;

	// One trial subtraction per cycle.
	assign trial = {rem_q, dvd_q[sorp_pkg::NUM_W-1]};
	assign qbit  = (trial >= {1'b0, dsr_q});
	assign diff  = trial - {1'b0, dsr_q};

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// Datapath: the dividend register shifts the quotient in from the right.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[sorp_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[sorp_pkg::TOT_W-1:0] : trial[sorp_pkg::TOT_W-1:0];
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (32'(cnt_q) == sorp_pkg::NUM_W - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorp_back.sv -----
// Back end: list buffer, pair table, training and prediction sequencer, output register.
// Depends on sorp_pkg and sorp_div.
`timescale 1ns / 1ps
`default_nettype none

module sorp_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sorp_pkg::entry_t                  q_entry,
	input  wire logic                              q_empty,
	output logic                                   pop,
	output logic                                   clr_busy,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [sorp_pkg::ITEM_W-1:0]            target_item,
	output logic signed [sorp_pkg::RAT_W-1:0]      prediction,
	output logic [sorp_pkg::WGT_W-1:0]             weight,
	output logic                                   valid_res,
	output logic                                   end_of_run
);

	sorp_pkg::back_state_t state_q, state_d;

	// Pair table: {diff_sum, pair_count} per word.
	logic [sorp_pkg::WORD_W-1:0] mem [sorp_pkg::TBL_DEPTH];
	logic [sorp_pkg::WORD_W-1:0] rd_word_q;
	logic                        mem_we;
	logic [sorp_pkg::ADDR_W-1:0] mem_wa;
	logic [sorp_pkg::WORD_W-1:0] mem_wd;
	logic [sorp_pkg::ADDR_W-1:0] rd_addr;

	// User list.
	logic [sorp_pkg::ITEM_W-1:0]   list_item_q   [sorp_pkg::MAX_PREFS];
	logic signed [sorp_pkg::RAT_W-1:0] list_rating_q [sorp_pkg::MAX_PREFS];
	logic [sorp_pkg::LEN_W-1:0]    len_q;
	logic [sorp_pkg::IDX_W-1:0]    sel_idx;
	logic [sorp_pkg::ITEM_W-1:0]   sel_item;
	logic signed [sorp_pkg::RAT_W-1:0] sel_rat;

	// Loop counters and working registers.
	logic [sorp_pkg::CLR_W-1:0]    clr_q;
	logic [sorp_pkg::LEN_W-1:0]    i_q;
	logic [sorp_pkg::LEN_W-1:0]    j_q;
	logic [sorp_pkg::T_W-1:0]      t_q;
	logic [sorp_pkg::N_W-1:0]      n_q;
	logic [sorp_pkg::ITEM_W-1:0]   a_q;
	logic signed [sorp_pkg::RAT_W-1:0] ra_q;
	logic signed [sorp_pkg::RAT_W-1:0] rb_q;
	logic [sorp_pkg::ADDR_W-1:0]   addr_q;
	logic signed [sorp_pkg::RAT_W-1:0] r_q;
	logic                          lt_q;
	logic                          seen_q;
	logic signed [sorp_pkg::PROD_W-1:0] prod_q;
	logic signed [sorp_pkg::SUM_W-1:0]  d_q;
	logic [sorp_pkg::CNT_W-1:0]    c_q;
	logic signed [sorp_pkg::NUM_W-1:0] num_q;
	logic [sorp_pkg::TOT_W-1:0]    tot_q;
	logic                          neg_q;
	logic signed [sorp_pkg::RAT_W-1:0] new_pred_q;
	logic [sorp_pkg::WGT_W-1:0]    new_wgt_q;

	// Held result and output register.
	logic                          pend_v_q;
	logic [sorp_pkg::ITEM_W-1:0]   pend_t_q;
	logic signed [sorp_pkg::RAT_W-1:0] pend_pred_q;
	logic [sorp_pkg::WGT_W-1:0]    pend_wgt_q;
	logic                          out_v_q;
	logic                          out_free;
	logic                          out_load;

	// Control strobes.
	logic                          div_start;
	logic [sorp_pkg::NUM_W-1:0]    div_q;
	sorp_pkg::div_stat_t           div_stat;
	logic                          t_end;
	logic                          skip_t;
	logic                          pair_hit;

	// Datapath helpers.
	logic signed [sorp_pkg::SUM_W-1:0] rd_sum;
	logic [sorp_pkg::CNT_W-1:0]    rd_cnt;
	logic signed [sorp_pkg::SUM_W:0]   tsum;
	logic signed [sorp_pkg::SUM_W-1:0] tsum_sat;
	logic [sorp_pkg::CNT_W-1:0]    tcnt;
	logic signed [sorp_pkg::CNT_W:0]   c_sgn;
	logic signed [sorp_pkg::PROD_W-1:0] prod_d;
	logic signed [sorp_pkg::TERM_W-1:0] term;
	logic [sorp_pkg::NUM_W-1:0]    mag;
	logic signed [sorp_pkg::RAT_W-1:0] q_sat;
	logic [sorp_pkg::WGT_W-1:0]    wgt_sat;
	logic [sorp_pkg::ITEM_W-1:0]   t_item;

	assign clr_busy  = (state_q == sorp_pkg::ST_CLEAR);
	assign out_valid = out_v_q;
	assign out_free  = ~out_v_q | ~out_stall;
	assign t_item    = t_q[sorp_pkg::ITEM_W-1:0];

	// One list read per cycle; the inner training loop walks j, all else walks i.
	assign sel_idx  = (state_q == sorp_pkg::ST_TRD) ? j_q[sorp_pkg::IDX_W-1:0]
	                                                 : i_q[sorp_pkg::IDX_W-1:0];
	assign sel_item = list_item_q[sel_idx];
	assign sel_rat  = list_rating_q[sel_idx];

	assign rd_sum = rd_word_q[sorp_pkg::WORD_W-1:sorp_pkg::CNT_W];
	assign rd_cnt = rd_word_q[sorp_pkg::CNT_W-1:0];

	// Training update with saturation of sum and count.
	assign tsum = $signed({rd_sum[sorp_pkg::SUM_W-1], rd_sum})
	            + (sorp_pkg::SUM_W+1)'($signed({ra_q[sorp_pkg::RAT_W-1], ra_q})
	                                   - $signed({rb_q[sorp_pkg::RAT_W-1], rb_q}));
	assign tsum_sat = (tsum[sorp_pkg::SUM_W] != tsum[sorp_pkg::SUM_W-1])
	                ? (tsum[sorp_pkg::SUM_W] ? sorp_pkg::SUM_MIN : sorp_pkg::SUM_MAX)
	                : tsum[sorp_pkg::SUM_W-1:0];
	assign tcnt = (rd_cnt == sorp_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

	// Prediction term: rating times count, minus or plus the difference sum.
	assign c_sgn  = $signed({1'b0, rd_cnt});
	assign prod_d = r_q * c_sgn;
	assign term   = lt_q ? (sorp_pkg::TERM_W'(prod_q) - sorp_pkg::TERM_W'(d_q))
	                     : (sorp_pkg::TERM_W'(prod_q) + sorp_pkg::TERM_W'(d_q));
	assign mag    = num_q[sorp_pkg::NUM_W-1] ? sorp_pkg::NUM_W'(-num_q)
	                                         : sorp_pkg::NUM_W'(num_q);

	// Quotient sign restore and clamp; weight clamp.
	always_comb begin
		if (neg_q) begin
			q_sat = (div_q > sorp_pkg::NUM_W'(sorp_pkg::Q_NEG_LIM)) ? sorp_pkg::Q_MIN
			      : -$signed(div_q[sorp_pkg::RAT_W-1:0]);
		end else begin
			q_sat = (div_q > sorp_pkg::NUM_W'(sorp_pkg::Q_POS_LIM)) ? sorp_pkg::Q_MAX
			      : $signed(div_q[sorp_pkg::RAT_W-1:0]);
		end
		wgt_sat = (32'(tot_q) > 32'(sorp_pkg::WEIGHT_MAX)) ? sorp_pkg::WEIGHT_MAX
		        : sorp_pkg::WGT_W'(tot_q);
	end

	assign t_end    = (32'(t_q) == sorp_pkg::NUM_ITEMS) || (32'(n_q) == sorp_pkg::RESULT_CAP);
	assign skip_t   = seen_q || (tot_q == '0);
	assign pair_hit = (sel_item > a_q);

	sorp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (tot_q),
		.quotient (div_q),
		.stat     (div_stat)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sorp_pkg::ST_CLEAR: begin
				if (32'(clr_q) == sorp_pkg::TBL_DEPTH - 1) state_d = sorp_pkg::ST_IDLE;
			end
			sorp_pkg::ST_IDLE: begin
				if (!q_empty && q_entry.last) begin
					state_d = (q_entry.mode == sorp_pkg::MODE_PREDICT) ? sorp_pkg::ST_PT
					                                                   : sorp_pkg::ST_TA;
				end
			end
			sorp_pkg::ST_TA:    state_d = (i_q == len_q) ? sorp_pkg::ST_IDLE : sorp_pkg::ST_TRD;
			sorp_pkg::ST_TRD: begin
				if (j_q == len_q) state_d = sorp_pkg::ST_TA;
				else if (pair_hit) state_d = sorp_pkg::ST_TWR;
			end
			sorp_pkg::ST_TWR:   state_d = sorp_pkg::ST_TRD;
			sorp_pkg::ST_PT:    state_d = t_end ? sorp_pkg::ST_PFIN : sorp_pkg::ST_PRD;
			sorp_pkg::ST_PRD:   state_d = (i_q == len_q) ? sorp_pkg::ST_PCHK : sorp_pkg::ST_PMUL;
			sorp_pkg::ST_PMUL:  state_d = sorp_pkg::ST_PACC;
			sorp_pkg::ST_PACC:  state_d = sorp_pkg::ST_PRD;
			sorp_pkg::ST_PCHK:  state_d = skip_t ? sorp_pkg::ST_PT : sorp_pkg::ST_PDIV;
			sorp_pkg::ST_PDIV: begin
				if (div_stat.done) state_d = sorp_pkg::ST_PPUSH;
			end
			sorp_pkg::ST_PPUSH: begin
				if (!pend_v_q || out_free) state_d = sorp_pkg::ST_PT;
			end
			sorp_pkg::ST_PFIN: begin
				if (out_free) state_d = sorp_pkg::ST_IDLE;
			end
			default: state_d = sorp_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = addr_q;
		mem_wd    = {tsum_sat, tcnt};
		rd_addr   = sorp_pkg::slot(a_q, sel_item);
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			sorp_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q[sorp_pkg::ADDR_W-1:0];
				mem_wd = '0;
			end
			sorp_pkg::ST_IDLE:  pop = ~q_empty;
			sorp_pkg::ST_TWR:   mem_we = 1'b1;
			sorp_pkg::ST_PRD: begin
				rd_addr = (sel_item < t_item) ? sorp_pkg::slot(sel_item, t_item)
				                              : sorp_pkg::slot(t_item, sel_item);
			end
			sorp_pkg::ST_PCHK:  div_start = ~skip_t;
			sorp_pkg::ST_PPUSH: out_load = pend_v_q & out_free;
			sorp_pkg::ST_PFIN:  out_load = out_free;
			default: ;
		endcase
	end

	// Pair table ports; read data registered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_word_q <= mem[rd_addr];
	end

	// List storage, written as words leave the queue.
	always_ff @(posedge clk) begin
		if (pop && q_entry.keep) begin
			list_item_q[len_q[sorp_pkg::IDX_W-1:0]]   <= q_entry.item;
			list_rating_q[len_q[sorp_pkg::IDX_W-1:0]] <= q_entry.rating;
		end
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			sorp_pkg::ST_TA: begin
				a_q  <= sel_item;
				ra_q <= sel_rat;
			end
			sorp_pkg::ST_TRD: begin
				rb_q   <= sel_rat;
				addr_q <= rd_addr;
			end
			sorp_pkg::ST_PT: begin
				num_q <= '0;
				tot_q <= '0;
			end
			sorp_pkg::ST_PRD: begin
				r_q  <= sel_rat;
				lt_q <= (sel_item < t_item);
			end
			sorp_pkg::ST_PMUL: begin
				prod_q <= prod_d;
				d_q    <= rd_sum;
				c_q    <= rd_cnt;
			end
			sorp_pkg::ST_PACC: begin
				num_q <= num_q + sorp_pkg::NUM_W'(term);
				tot_q <= tot_q + sorp_pkg::TOT_W'(c_q);
			end
			sorp_pkg::ST_PCHK:  neg_q <= num_q[sorp_pkg::NUM_W-1];
			sorp_pkg::ST_PDIV: begin
				new_pred_q <= q_sat;
				new_wgt_q  <= wgt_sat;
			end
			default: ;
		endcase
	end

	// Held result and output payload.
	always_ff @(posedge clk) begin
		if (state_q == sorp_pkg::ST_PPUSH && (!pend_v_q || out_free)) begin
			pend_t_q    <= t_item;
			pend_pred_q <= new_pred_q;
			pend_wgt_q  <= new_wgt_q;
		end
		if (out_load) begin
			if (pend_v_q) begin
				target_item <= pend_t_q;
				prediction  <= pend_pred_q;
				weight      <= pend_wgt_q;
				valid_res   <= 1'b1;
			end else begin
				target_item <= '0;
				prediction  <= '0;
				weight      <= '0;
				valid_res   <= 1'b0;
			end
			end_of_run <= (state_q == sorp_pkg::ST_PFIN);
		end
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sorp_pkg::ST_CLEAR;
			clr_q    <= '0;
			len_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			n_q      <= '0;
			seen_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				sorp_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				sorp_pkg::ST_IDLE: begin
					i_q <= '0;
					t_q <= '0;
					n_q <= '0;
					if (pop && q_entry.keep) len_q <= len_q + 1'b1;
				end
				sorp_pkg::ST_TA: begin
					j_q <= '0;
					if (i_q == len_q) len_q <= '0;
				end
				sorp_pkg::ST_TRD: begin
					if (j_q == len_q) i_q <= i_q + 1'b1;
					else if (!pair_hit) j_q <= j_q + 1'b1;
				end
				sorp_pkg::ST_TWR:   j_q <= j_q + 1'b1;
				sorp_pkg::ST_PT: begin
					i_q    <= '0;
					seen_q <= 1'b0;
				end
				sorp_pkg::ST_PRD: begin
					if (i_q != len_q && sel_item == t_item) seen_q <= 1'b1;
				end
				sorp_pkg::ST_PACC:  i_q <= i_q + 1'b1;
				sorp_pkg::ST_PCHK: begin
					if (skip_t) t_q <= t_q + 1'b1;
				end
				sorp_pkg::ST_PPUSH: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
						t_q      <= t_q + 1'b1;
					end
				end
				sorp_pkg::ST_PFIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						len_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/slope_one_rating_predictor.sv -----
// Top level of the weighted slope-one rating predictor.
// Depends on sorp_pkg, sorp_front, sorp_fifo and sorp_back.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------------
//  input   | in_valid / in_stall   | mode, item, rating, last
//  output  | out_valid / out_stall | target_item, prediction, weight, valid_res, end_of_run
//
// A word that does not close its list is popped and stored while the back end stays idle.
// A closing training word walks all L*L list pairs (L = list length), reading each pair
// and writing its pair table entry back for each pair with a < b.
// A closing query word reads, weights and sums every list entry per target item, then
// runs the divider and pushes a result for each prediction.
// After reset the pair table is cleared, all 4096 words, during which in_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module slope_one_rating_predictor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              mode,
	input  wire logic [sorp_pkg::ITEM_W-1:0]       item,
	input  wire logic signed [sorp_pkg::RAT_W-1:0] rating,
	input  wire logic                              last,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [sorp_pkg::ITEM_W-1:0]            target_item,
	output logic signed [sorp_pkg::RAT_W-1:0]      prediction,
	output logic [sorp_pkg::WGT_W-1:0]             weight,
	output logic                                   valid_res,
	output logic                                   end_of_run
);

	sorp_pkg::entry_t  wr_entry;
	sorp_pkg::entry_t  rd_entry;
	sorp_pkg::fe_ctl_t fe_ctl;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	logic              clr_busy;

	assign fe_ctl.clr_busy = clr_busy;
	assign fe_ctl.q_full   = q_full;

	// Front end accepts and classifies words.
	sorp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.item     (item),
		.rating   (rating),
		.last     (last),
		.ctl      (fe_ctl),
		.push     (push),
		.entry    (wr_entry)
	);

	// Queue decouples the two sides.
	sorp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back end runs training and prediction.
	sorp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_entry     (rd_entry),
		.q_empty     (q_empty),
		.pop         (pop),
		.clr_busy    (clr_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.target_item (target_item),
		.prediction  (prediction),
		.weight      (weight),
		.valid_res   (valid_res),
		.end_of_run  (end_of_run)
	);

	// The queue is never written while full nor read while empty.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !push)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) q_empty |-> !pop)
		else $error("queue read while empty");

	// Nothing is queued while the table clear runs.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy) |-> q_empty)
		else $error("word queued during table clear");

endmodule

`default_nettype wire
